@@ hdl/bit_parallel_gate_netlist_evaluator_unit_defines.svh @@
// Assertion macros shared by the netlist evaluator RTL.
`ifndef BIT_PARALLEL_GATE_NETLIST_EVALUATOR_UNIT_DEFINES_SVH
`define BIT_PARALLEL_GATE_NETLIST_EVALUATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BPGNE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BPGNE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bpgne_pkg.sv @@
// Package with field widths, codes and defaults of the netlist evaluator.
`timescale 1ns / 1ps
package bpgne_pkg;

  localparam int unsigned NODE_W = 10;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned CFG_W  = 4;

  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned MAX_WORDS_DEF = 8;

  localparam logic [CFG_W-1:0] WORDS_IN_USE_RST = 4'd8;

  // Input tdata layout, lowest bit first.
  localparam int unsigned OFS_NODE = 0;
  localparam int unsigned OFS_SLOT = OFS_NODE + NODE_W;
  localparam int unsigned OFS_OP   = OFS_SLOT + SLOT_W;
  localparam int unsigned OFS_A    = OFS_OP + OP_W;
  localparam int unsigned OFS_B    = OFS_A + NODE_W;
  localparam int unsigned OFS_C    = OFS_B + NODE_W;
  localparam int unsigned OFS_SRC  = OFS_C + NODE_W;
  localparam int unsigned IN_BITS  = OFS_SRC + WORD_W;
  localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout, lowest bit first.
  localparam int unsigned OUT_BITS    = NODE_W + SLOT_W + WORD_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [NODE_W-1:0] NODE_ZERO = 10'd0;
  localparam logic [NODE_W-1:0] NODE_ONES = 10'd1;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_SOURCE = 3'd0,
    OP_NOT    = 3'd1,
    OP_AND    = 3'd2,
    OP_OR     = 3'd3,
    OP_XOR    = 3'd4,
    OP_MUX    = 3'd5
  } node_op_e;

  // Where an operand word comes from.
  typedef enum logic [1:0] {
    OPND_MEM  = 2'd0,
    OPND_ZERO = 2'd1,
    OPND_ONES = 2'd2
  } opnd_kind_e;

  typedef struct packed {
    opnd_kind_e kind;
    logic       hit;
  } opnd_ctl_t;

endpackage

@@ hdl/bit_parallel_gate_netlist_evaluator_unit.sv @@
// Top level of the bit-parallel gate netlist evaluator.
`timescale 1ns / 1ps
`include "bit_parallel_gate_netlist_evaluator_unit_defines.svh"
// Usage:
// The slave stream carries one node word per transfer: the destination node,
// its word slot, the gate operation, three operand node indices and a source
// word. The master stream returns one transfer per input transfer, in order,
// holding the node, the slot and the computed 64-pattern word; tuser flags a
// slot at or above the configured word count, in which case the word is zero
// and nothing is stored.
// The configuration channel writes the number of words in use; it is always
// ready and is meant to be written only while the block is idle.
// A result passes through the compute stage register and then the output
// register before it is presented on the master stream.
// Throughput is one item per cycle while the receiver does not stall: the value
// store is read for the next item while the current one computes and writes
// back, and a one-entry bypass covers an operand that the item just ahead writes.
// The value store is two identical synchronous memories, one with two read
// ports for the first and second operand and one for the third, both written
// with every stored result. Their contents are undefined after reset and need no
// clearing pass; reset empties the pipeline and restores eight words in use.
// When the receiver stalls, the result holds in the output register, one more
// item waits in the compute stage, and then the input stalls too.
module bit_parallel_gate_netlist_evaluator_unit #(
  parameter int unsigned MAX_NODES = bpgne_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_WORDS = bpgne_pkg::MAX_WORDS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream. tdata from bit 0: node_id, word_index, node_op, operand_a,
  // operand_b, operand_c, source_word, zero padding.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bpgne_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Result stream. tdata from bit 0: out_node, out_word, value, zero padding.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bpgne_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // tuser: bad_slot.
  output logic                               m_axis_tuser,
  // Configuration write of words_in_use.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bpgne_pkg::CFG_W-1:0]        cfg_data_i
);
  import bpgne_pkg::*;

  localparam int unsigned DEPTH = MAX_NODES * MAX_WORDS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW    = NODE_W + 8;

  // Flat store address of a node word: node times words per node plus slot.
  function automatic logic [AW-1:0] addr_of(logic [NODE_W-1:0] node,
                                            logic [SLOT_W-1:0] slot);
    logic [PW-1:0] prod;
    prod = PW'(node) * PW'(MAX_WORDS) + PW'(slot);
    return AW'(prod);
  endfunction

  // Nodes zero and one are constants, nodes past the netlist read as zero.
  function automatic opnd_kind_e kind_of(logic [NODE_W-1:0] node);
    opnd_kind_e k;
    if (node == NODE_ZERO) begin
      k = OPND_ZERO;
    end else if (node == NODE_ONES) begin
      k = OPND_ONES;
    end else if (32'(node) >= MAX_NODES) begin
      k = OPND_ZERO;
    end else begin
      k = OPND_MEM;
    end
    return k;
  endfunction

  function automatic word_t opnd_val(opnd_ctl_t ctl, word_t rd, word_t fwd);
    word_t w;
    unique case (ctl.kind)
      OPND_ZERO: w = '0;
      OPND_ONES: w = '1;
      OPND_MEM:  w = ctl.hit ? fwd : rd;
      default:   w = '0;
    endcase
    return w;
  endfunction

  // Input field unpacking.
  logic [NODE_W-1:0] in_node, in_a, in_b, in_c;
  logic [SLOT_W-1:0] in_slot;
  logic [OP_W-1:0]   in_op;
  word_t             in_src;

  assign in_node = s_axis_tdata[OFS_NODE +: NODE_W];
  assign in_slot = s_axis_tdata[OFS_SLOT +: SLOT_W];
  assign in_op   = s_axis_tdata[OFS_OP   +: OP_W];
  assign in_a    = s_axis_tdata[OFS_A    +: NODE_W];
  assign in_b    = s_axis_tdata[OFS_B    +: NODE_W];
  assign in_c    = s_axis_tdata[OFS_C    +: NODE_W];
  assign in_src  = s_axis_tdata[OFS_SRC  +: WORD_W];

  // Configuration register.
  logic [CFG_W-1:0] words_in_use_q;

  assign cfg_ready_o = 1'b1;

  // Compute stage and output register.
  logic              s1_valid_q;
  logic [NODE_W-1:0] s1_node_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic [OP_W-1:0]   s1_op_q;
  word_t             s1_src_q;
  logic              s1_bad_q;
  logic              s1_store_q;
  logic [AW-1:0]     s1_waddr_q;
  opnd_ctl_t         s1_ctl_a_q, s1_ctl_b_q, s1_ctl_c_q;
  word_t             rd_a_q, rd_b_q, rd_c_q;
  word_t             wr_data_q;

  logic              out_valid_q;
  logic [NODE_W-1:0] out_node_q;
  logic [SLOT_W-1:0] out_slot_q;
  word_t             out_value_q;
  logic              out_bad_q;

  word_t mem_ab_q [DEPTH];
  word_t mem_c_q  [DEPTH];

  logic      out_free, s1_adv, in_xfer, wr_en, in_bad;
  opnd_ctl_t ctl_a_d, ctl_b_d, ctl_c_d;
  word_t     opa, opb, opc, gate_val, res_val;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign wr_en         = s1_adv && !s1_bad_q && s1_store_q;

  // A slot is rejected against both the configured and the built word count.
  assign in_bad = ({1'b0, in_slot} >= words_in_use_q) || (32'(in_slot) >= MAX_WORDS);

  // The store read for a new item lands on the same edge as the write of the
  // item ahead, so a match on that write is flagged and served from wr_data_q.
  always_comb begin
    ctl_a_d.kind = kind_of(in_a);
    ctl_b_d.kind = kind_of(in_b);
    ctl_c_d.kind = kind_of(in_c);
    ctl_a_d.hit  = wr_en && (in_a == s1_node_q) && (in_slot == s1_slot_q);
    ctl_b_d.hit  = wr_en && (in_b == s1_node_q) && (in_slot == s1_slot_q);
    ctl_c_d.hit  = wr_en && (in_c == s1_node_q) && (in_slot == s1_slot_q);
  end

  // Gate evaluation on the three operand words.
  always_comb begin
    opa = opnd_val(s1_ctl_a_q, rd_a_q, wr_data_q);
    opb = opnd_val(s1_ctl_b_q, rd_b_q, wr_data_q);
    opc = opnd_val(s1_ctl_c_q, rd_c_q, wr_data_q);
    unique case (s1_op_q)
      OP_SOURCE: gate_val = s1_src_q;
      OP_NOT:    gate_val = ~opa;
      OP_AND:    gate_val = opa & opb;
      OP_OR:     gate_val = opa | opb;
      OP_XOR:    gate_val = opa ^ opb;
      OP_MUX:    gate_val = (opa & opb) | (~opa & opc);
      default:   gate_val = '0;
    endcase
    res_val = s1_bad_q ? '0 : gate_val;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_in_use_q <= WORDS_IN_USE_RST;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        words_in_use_q <= cfg_data_i;
      end
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the compute stage and the output register.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_node_q  <= in_node;
      s1_slot_q  <= in_slot;
      s1_op_q    <= in_op;
      s1_src_q   <= in_src;
      s1_bad_q   <= in_bad;
      s1_store_q <= 32'(in_node) < MAX_NODES;
      s1_waddr_q <= addr_of(in_node, in_slot);
      s1_ctl_a_q <= ctl_a_d;
      s1_ctl_b_q <= ctl_b_d;
      s1_ctl_c_q <= ctl_c_d;
    end
    if (wr_en) begin
      wr_data_q <= res_val;
    end
    if (s1_adv) begin
      out_node_q  <= s1_node_q;
      out_slot_q  <= s1_slot_q;
      out_value_q <= res_val;
      out_bad_q   <= s1_bad_q;
    end
  end

  // Value store: both copies take every write, reads issue with the transfer.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_ab_q[s1_waddr_q] <= res_val;
      mem_c_q[s1_waddr_q]  <= res_val;
    end
    if (in_xfer) begin
      rd_a_q <= mem_ab_q[addr_of(in_a, in_slot)];
      rd_b_q <= mem_ab_q[addr_of(in_b, in_slot)];
      rd_c_q <= mem_c_q[addr_of(in_c, in_slot)];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_value_q, out_slot_q, out_node_q});
  assign m_axis_tuser  = out_bad_q;

  // A rejected item always reports a zero word.
  `BPGNE_ASSERT_IMP(a_bad_value_zero, out_valid_q && out_bad_q, out_value_q == '0, "bad slot with nonzero value")
  // An item leaving the compute stage is presented on the next cycle.
  `BPGNE_ASSERT_NEXT(a_adv_presents, s1_adv, out_valid_q, "advanced item not presented")
  // A bypass flag is only raised for an item whose read met a write.
  `BPGNE_ASSERT_NEXT(a_hit_needs_write, in_xfer && !wr_en, !(s1_ctl_a_q.hit || s1_ctl_b_q.hit || s1_ctl_c_q.hit), "bypass flagged without write")
  // A result leaves the output register only through a transfer.
  `BPGNE_ASSERT_IMP(a_no_lost_result, $fell(out_valid_q), $past(m_axis_tready), "result dropped without transfer")

endmodule
